/* hdl/xfec_pkg.sv */
// Shared types and constants for the XOR parity FEC encoder.
`timescale 1ns / 1ps
package xfec_pkg;

    localparam int MAX_GROUP     = 32;
    localparam int PAYLOAD_BYTES = 160;
    localparam int DEPTH         = MAX_GROUP * PAYLOAD_BYTES;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int SEQ_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 8;
    localparam int GS_W          = 6;
    localparam int SLOT_W        = $clog2(MAX_GROUP);
    localparam int BIT_CNT_W     = $clog2(SEQ_W);

    localparam logic [GS_W-1:0]  GS_RESET = GS_W'(3);
    localparam logic [GS_W-1:0]  GS_MIN   = GS_W'(1);
    localparam logic [GS_W-1:0]  GS_MAX   = GS_W'(MAX_GROUP);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic wr_item;
        logic rd_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic closes;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* hdl/xfec_ctrl.sv */
// Control state machine for the XOR parity FEC encoder.
`timescale 1ns / 1ps
module xfec_ctrl
    import xfec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MOD;
            end
            ST_MOD: begin
                if (i_sts.mod_done) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = i_sts.closes ? ST_READ : ST_FINISH;
            end
            ST_READ: begin
                if (i_sts.rd_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            ST_WRITE: begin
                o_cmd.wr_item = 1'b1;
            end
            ST_READ: begin
                o_cmd.rd_step = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd = '0;
            end
            ST_FINISH: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/xfec_dp.sv */
// Datapath: group store, serial remainder unit, parity accumulator, output register.
`timescale 1ns / 1ps
module xfec_dp
    import xfec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_cfg_we,
    input  logic [GS_W-1:0]   i_cfg_data,
    input  logic [SEQ_W-1:0]  i_frame_seq,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [SEQ_W-1:0]  o_data_seq,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [BYTE_W-1:0] o_data_out,
    output logic              o_frame_end,
    output logic              o_parity_valid,
    output logic [SEQ_W-1:0]  o_parity_base_seq,
    output logic [GS_W-1:0]   o_parity_group_size,
    output logic [BYTE_W-1:0] o_parity_out
);

    logic [BYTE_W-1:0] r_mem [DEPTH];

    logic [GS_W-1:0]      r_grp_cfg;
    logic [POS_W-1:0]     r_byte_cnt;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [SEQ_W-1:0]     r_seq;
    logic [SEQ_W-1:0]     r_div;
    logic [BYTE_W-1:0]    r_byte;
    logic [POS_W-1:0]     r_pos;
    logic [GS_W-1:0]      r_gs;
    logic [SLOT_W-1:0]    r_rem;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [ADDR_W-1:0]    r_rd_addr;
    logic [SLOT_W-1:0]    r_k;
    logic                 r_rd_vld;
    logic [BYTE_W-1:0]    r_rdata;
    logic [BYTE_W-1:0]    r_par;
    logic                 r_out_valid;

    logic [GS_W-1:0]   n_cfg_gs;
    logic [GS_W-1:0]   n_trial;
    logic [GS_W-1:0]   n_rem;
    logic [ADDR_W-1:0] n_item_addr;
    logic [ADDR_W-1:0] n_wr_addr;
    logic [BYTE_W-1:0] n_wr_data;
    logic              n_wr_en;
    logic              n_closes;

    always_comb begin
        if (i_cfg_data < GS_MIN) begin
            n_cfg_gs = GS_MIN;
        end else if (i_cfg_data > GS_MAX) begin
            n_cfg_gs = GS_MAX;
        end else begin
            n_cfg_gs = i_cfg_data;
        end
    end

    always_comb begin
        n_trial = {r_rem, r_div[SEQ_W-1]};
        n_rem   = (n_trial >= r_gs) ? n_trial - r_gs : n_trial;
    end

    assign n_item_addr = ADDR_W'(r_rem) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(r_pos);
    assign n_wr_en     = i_cmd.clr_step | i_cmd.wr_item;
    assign n_wr_addr   = i_cmd.clr_step ? r_clr_addr : n_item_addr;
    assign n_wr_data   = i_cmd.clr_step ? '0 : r_byte;
    assign n_closes    = ({1'b0, r_rem} == r_gs - GS_W'(1));

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        r_rdata <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_cfg   <= GS_RESET;
            r_byte_cnt  <= '0;
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grp_cfg <= n_cfg_gs;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.load) begin
                r_byte_cnt <= (r_byte_cnt == POS_LAST) ? '0 : r_byte_cnt + POS_W'(1);
            end
            r_rd_vld <= i_cmd.rd_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq     <= i_frame_seq;
            r_div     <= i_frame_seq;
            r_byte    <= i_payload_byte;
            r_pos     <= r_byte_cnt;
            r_gs      <= r_grp_cfg;
            r_rem     <= '0;
            r_bit_cnt <= '0;
            r_rd_addr <= ADDR_W'(r_byte_cnt);
            r_k       <= '0;
            r_par     <= '0;
        end else begin
            if (i_cmd.mod_step) begin
                r_rem     <= n_rem[SLOT_W-1:0];
                r_div     <= {r_div[SEQ_W-2:0], 1'b0};
                r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
            end
            if (i_cmd.rd_step) begin
                r_rd_addr <= r_rd_addr + ADDR_W'(PAYLOAD_BYTES);
                r_k       <= r_k + SLOT_W'(1);
            end
            if (r_rd_vld) begin
                r_par <= r_par ^ r_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_data_seq      <= r_seq;
            o_byte_position <= r_pos;
            o_data_out      <= r_byte;
            o_frame_end     <= (r_pos == POS_LAST);
            o_parity_valid  <= n_closes;
            if (n_closes) begin
                o_parity_base_seq   <= r_seq - (SEQ_W'(r_gs) - SEQ_W'(1));
                o_parity_group_size <= r_gs;
                o_parity_out        <= r_par;
            end else begin
                o_parity_base_seq   <= '0;
                o_parity_group_size <= '0;
                o_parity_out        <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.mod_done = (r_bit_cnt == BIT_CNT_W'(SEQ_W - 1));
    assign o_sts.closes   = n_closes;
    assign o_sts.rd_last  = ({1'b0, r_k} == r_gs - GS_W'(1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

endmodule

/* hdl/xor_parity_fec_encoder.sv */
// Top level of the XOR parity FEC encoder.
// Takes one payload byte per transaction, stores it in the group store at
// (frame_seq mod group size, byte position) and returns one result per byte:
// the echoed data byte with its header fields and, when the byte's slot closes
// a group, the XOR parity over its group's slots at that byte position. After
// reset the 5120-entry group store is cleared one entry per cycle, so the
// input stalls until the clear is done; group size writes are taken during
// that time. Each byte's slot then comes from a one-bit-per-cycle remainder
// unit over the 32-bit sequence number and, when the byte closes a group, the
// parity reads the store one slot per cycle. The next byte can be accepted in
// the cycle after the result is loaded; a finished result waits in an output
// register while the next byte is accepted.
`timescale 1ns / 1ps
module xor_parity_fec_encoder
    import xfec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GS_W-1:0]   i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [SEQ_W-1:0]  i_frame_seq,
    input  logic [BYTE_W-1:0] i_payload_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [SEQ_W-1:0]  o_data_seq,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [BYTE_W-1:0] o_data_out,
    output logic              o_frame_end,
    output logic              o_parity_valid,
    output logic [SEQ_W-1:0]  o_parity_base_seq,
    output logic [GS_W-1:0]   o_parity_group_size,
    output logic [BYTE_W-1:0] o_parity_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    xfec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    xfec_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_frame_seq         (i_frame_seq),
        .i_payload_byte      (i_payload_byte),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_data_seq          (o_data_seq),
        .o_byte_position     (o_byte_position),
        .o_data_out          (o_data_out),
        .o_frame_end         (o_frame_end),
        .o_parity_valid      (o_parity_valid),
        .o_parity_base_seq   (o_parity_base_seq),
        .o_parity_group_size (o_parity_group_size),
        .o_parity_out        (o_parity_out)
    );

endmodule

/* hdl/xfec_checker.sv */
// Port-level checks for the XOR parity FEC encoder, bound to the top level.
`timescale 1ns / 1ps
module xfec_checker
    import xfec_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [SEQ_W-1:0]  o_data_seq,
    input logic [POS_W-1:0]  o_byte_position,
    input logic              o_frame_end,
    input logic              o_parity_valid,
    input logic [SEQ_W-1:0]  o_parity_base_seq,
    input logic [GS_W-1:0]   o_parity_group_size,
    input logic [BYTE_W-1:0] o_parity_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_seq))
        else $error("result dropped or changed while stalled");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_end == (o_byte_position == POS_LAST)))
        else $error("frame_end does not match byte position");

    a_no_parity_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_parity_valid |->
            o_parity_base_seq == '0 && o_parity_group_size == '0 && o_parity_out == '0)
        else $error("parity fields not zero without parity");

    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parity_valid |->
            o_parity_group_size >= GS_MIN && o_parity_group_size <= GS_MAX)
        else $error("parity group size out of range");

    a_base_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parity_valid |->
            o_parity_base_seq == o_data_seq - (SEQ_W'(o_parity_group_size) - SEQ_W'(1)))
        else $error("parity base sequence mismatch");

endmodule

bind xor_parity_fec_encoder xfec_checker u_xfec_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_data_seq          (o_data_seq),
    .o_byte_position     (o_byte_position),
    .o_frame_end         (o_frame_end),
    .o_parity_valid      (o_parity_valid),
    .o_parity_base_seq   (o_parity_base_seq),
    .o_parity_group_size (o_parity_group_size),
    .o_parity_out        (o_parity_out)
);
